// ===== design/kwsm_pkg.sv =====
package kwsm_pkg;

  localparam int unsigned MaxListsDef   = 16;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned PortValueW    = 32;
  localparam int unsigned SourceW       = 4;

  typedef struct packed {
    logic                          operation;
    logic [SourceW-1:0]            source;
    logic signed [PortValueW-1:0]  value;
    logic                          present;
  } in_item_t;

  typedef struct packed {
    logic signed [PortValueW-1:0]  min_value;
    logic [SourceW-1:0]            min_source;
    logic                          valid_res;
    logic                          last;
  } out_item_t;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpMerge = 1'b1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StCmp  = 5'b00010,
    StWr   = 5'b00100,
    StPop  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

endpackage

// ===== design/kwsm_ram.sv =====
module kwsm_ram #(
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 36
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/k_way_sorted_merge.sv =====
// Sorted merge of up to MAX_LISTS ascending streams through a priority queue.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): a load item
// (operation = 0) inserts a stream head and gives no result; a merge item
// inserts its element when present is set, then removes the minimum and gives
// one result on the output channel (out_valid_o / out_stall_i, out_data_o).
// A result names the stream to refill next, flags an empty queue (valid_res
// low) and marks the final element (last). Ties go to the lower source index.
// Inserts into a full queue are dropped.
// The queue is an ordered circular buffer in one RAM; a pop only moves the
// head pointer. An insert walks down from the tail with one comparator,
// moving one entry per cycle past the entries that sort after the new
// element, then writes it. A merge item adds a head read and the result
// transfer.
// in_stall_o is high while an item is being worked on. A finished result sits
// in an output register; the block accepts the next item while it waits, and
// a later pop holds until the receiver takes it.
// Reset empties the queue at once; no clearing pass is needed.
module k_way_sorted_merge #(
  parameter int unsigned MAX_LISTS   = kwsm_pkg::MaxListsDef,
  parameter int unsigned VALUE_WIDTH = kwsm_pkg::ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kwsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kwsm_pkg::out_item_t out_data_o
);

  import kwsm_pkg::*;

  localparam int unsigned IdxW   = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int unsigned CntW   = $clog2(MAX_LISTS + 1);
  localparam int unsigned EntryW = VALUE_WIDTH + SourceW;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] head_q, head_d;
  logic            merge_q, merge_d;
  logic [VALUE_WIDTH-1:0] new_val_q, new_val_d;
  logic [SourceW-1:0]     new_src_q, new_src_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic              wr_en, rd_en;
  logic [IdxW-1:0]   wr_addr, rd_addr;
  logic [EntryW-1:0] wr_data, rd_data;

  logic [VALUE_WIDTH+PortValueW-1:0] in_ext, out_ext;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [SourceW-1:0]     rd_src;
  logic                   new_first;
  logic                   in_take, out_free, full;

  kwsm_ram #(
    .AddrW (IdxW),
    .DataW (EntryW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_ext   = {{VALUE_WIDTH{1'b0}}, in_data_i.value};
  assign {rd_val, rd_src} = rd_data;
  assign out_ext  = {{PortValueW{1'b0}}, rd_val};
  assign in_take  = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CntW'(MAX_LISTS));

  // strict order: value first, then lower source
  assign new_first = ($signed(new_val_q) < $signed(rd_val)) ||
                     ((new_val_q == rd_val) && (new_src_q < rd_src));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    head_d      = head_q;
    merge_d     = merge_q;
    new_val_d   = new_val_q;
    new_src_d   = new_src_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    wr_en       = 1'b0;
    wr_addr     = head_q + pos_q[IdxW-1:0];
    wr_data     = {new_val_q, new_src_q};
    rd_en       = 1'b0;
    rd_addr     = head_q + IdxW'(count_q - CntW'(1));

    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          merge_d   = (in_data_i.operation == OpMerge);
          new_val_d = in_ext[VALUE_WIDTH-1:0];
          new_src_d = in_data_i.source;
          pos_d     = count_q;
          if (in_data_i.present && !full) begin
            if (count_q == '0) begin
              state_d = StWr;
            end else begin
              rd_en   = 1'b1;
              state_d = StCmp;
            end
          end else if (in_data_i.operation == OpMerge) begin
            state_d = StPop;
          end
        end
      end
      StCmp: begin
        wr_en = 1'b1;
        if (new_first) begin
          // move the tail entry up one slot and look one further down
          wr_data = rd_data;
          pos_d   = pos_q - CntW'(1);
          if (pos_q == CntW'(1)) begin
            state_d = StWr;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_q + IdxW'(pos_q - CntW'(2));
          end
        end else begin
          count_d = count_q + CntW'(1);
          state_d = merge_q ? StPop : StIdle;
        end
      end
      StWr: begin
        wr_en   = 1'b1;
        count_d = count_q + CntW'(1);
        state_d = merge_q ? StPop : StIdle;
      end
      StPop: begin
        if (count_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = '0;
            state_d     = StIdle;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_data_d.min_value  = out_ext[PortValueW-1:0];
          out_data_d.min_source = rd_src;
          out_data_d.valid_res  = 1'b1;
          out_data_d.last       = (count_q == CntW'(1));
          head_d                = head_q + IdxW'(1);
          count_d               = count_q - CntW'(1);
          state_d               = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    merge_q    <= merge_d;
    new_val_q  <= new_val_d;
    new_src_q  <= new_src_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== verif/tb.sv =====
module tb;
  import kwsm_pkg::*;

  localparam int unsigned NumLists   = MaxListsDef;
  localparam int unsigned ItemTarget = 1000;
  localparam int unsigned TailCycles = NumLists + 8;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // predictor state: ordered heads, smallest first
  logic signed [PortValueW-1:0] sorted_val [NumLists];
  logic [SourceW-1:0]           sorted_src [NumLists];
  int unsigned                  held_count = 0;

  out_item_t                    pending_min [$];
  logic signed [PortValueW-1:0] stream_q [NumLists][$];

  int unsigned items_sent = 0;
  int unsigned err_count = 0;
  int unsigned rx_hold = 0;
  int unsigned idle_cycles = 0;
  bit          calm_phase = 1'b0;

  k_way_sorted_merge i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic in_item_t make_item(input logic op, input logic [SourceW-1:0] src,
                                         input logic [PortValueW-1:0] val,
                                         input logic pres);
    in_item_t it;
    it.operation = op;
    it.source    = src;
    it.value     = val;
    it.present   = pres;
    return it;
  endfunction

  // insert the element if present, then pop the minimum on a merge
  function automatic bit merge_predict(input in_item_t it, output out_item_t res);
    int pos;
    res = '0;
    if (it.present && held_count < NumLists) begin
      pos = held_count;
      while (pos > 0 && ($signed(it.value) < sorted_val[pos-1] ||
             ($signed(it.value) == sorted_val[pos-1] && it.source < sorted_src[pos-1]))) begin
        sorted_val[pos] = sorted_val[pos-1];
        sorted_src[pos] = sorted_src[pos-1];
        pos--;
      end
      sorted_val[pos] = it.value;
      sorted_src[pos] = it.source;
      held_count++;
    end
    if (it.operation == OpLoad) return 1'b0;
    if (held_count != 0) begin
      res.min_value  = sorted_val[0];
      res.min_source = sorted_src[0];
      res.valid_res  = 1'b1;
      for (int i = 1; i < held_count; i++) begin
        sorted_val[i-1] = sorted_val[i];
        sorted_src[i-1] = sorted_src[i];
      end
      held_count--;
      res.last = (held_count == 0);
    end
    return 1'b1;
  endfunction

  // entered and left at a rising edge
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                           output out_item_t pred);
    int unsigned gap;
    gap = calm_phase ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.operation == OpMerge || it.present) items_sent++;
    if (merge_predict(it, pred)) pending_min.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_min.size() != 0) @(posedge clk_i);
  endtask

  // pop until the queue reports empty, refilling from the stream just drained
  task automatic merge_until_empty(input logic [SourceW-1:0] first_src);
    out_item_t        pred;
    logic [SourceW-1:0] src;
    int unsigned      guard;
    bit               more;
    src   = first_src;
    guard = 0;
    more  = 1'b1;
    while (more && guard < 300) begin
      if (stream_q[src].size() != 0)
        send_item(make_item(OpMerge, src, stream_q[src].pop_front(), 1'b1), 1'b0, '0, pred);
      else
        send_item(make_item(OpMerge, src, $urandom(), 1'b0), 1'b0, '0, pred);
      src   = pred.min_source;
      more  = pred.valid_res && !(pred.last && stream_q[src].size() == 0);
      guard++;
    end
  endtask

  task automatic run_merge_set();
    int unsigned n_streams;
    int unsigned base;
    int unsigned len;
    int unsigned mode;
    int unsigned s;
    longint      cur;
    out_item_t   pred;
    n_streams = ($urandom_range(0, 4) == 0) ? NumLists : $urandom_range(1, 6);
    base      = $urandom_range(0, NumLists - 1);
    for (int i = 0; i < NumLists; i++) stream_q[i].delete();
    for (int i = 0; i < n_streams; i++) begin
      s    = (base + i) % NumLists;
      len  = $urandom_range(0, 7);
      mode = $urandom_range(0, 3);
      case (mode)
        0: cur = longint'($urandom_range(0, 16)) - 8;
        1: cur = longint'($signed($urandom()));
        2: cur = 64'sd2147483647 - longint'($urandom_range(0, 20));
        default: cur = -64'sd2147483648 + longint'($urandom_range(0, 20));
      endcase
      for (int k = 0; k < len && cur <= 64'sd2147483647; k++) begin
        stream_q[s].push_back(cur[PortValueW-1:0]);
        cur += (mode == 1) ? longint'($urandom_range(0, 1 << 28))
                           : longint'($urandom_range(0, 3));
      end
    end
    // load heads; now and then skip a stream to break the sequence
    for (int i = 0; i < n_streams; i++) begin
      s = (base + i) % NumLists;
      if ($urandom_range(0, 19) == 0) begin
        stream_q[s].delete();
      end else if (stream_q[s].size() != 0) begin
        send_item(make_item(OpLoad, SourceW'(s), stream_q[s].pop_front(), 1'b1),
                  1'b0, '0, pred);
      end else begin
        send_item(make_item(OpLoad, SourceW'(s), $urandom(), 1'b0), 1'b0, '0, pred);
      end
    end
    send_item(make_item(OpMerge, SourceW'(base), $urandom(), 1'b0), 1'b0, '0, pred);
    if (pred.valid_res && !(pred.last && stream_q[pred.min_source].size() == 0))
      merge_until_empty(pred.min_source);
  endtask

  // overfill the queue so that late inserts are dropped, then empty it
  task automatic run_fill_burst();
    out_item_t pred;
    int unsigned n;
    n = $urandom_range(NumLists, NumLists + 4);
    for (int i = 0; i < NumLists; i++) stream_q[i].delete();
    for (int i = 0; i < n; i++)
      send_item(make_item(OpLoad, SourceW'($urandom_range(0, NumLists - 1)), $urandom(),
                          1'b1), 1'b0, '0, pred);
    merge_until_empty(SourceW'($urandom_range(0, NumLists - 1)));
  endtask

  task automatic run_noise();
    out_item_t pred;
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      send_item(make_item(1'($urandom_range(0, 1)), SourceW'($urandom_range(0, NumLists - 1)),
                          $urandom(), 1'($urandom_range(0, 1))), 1'b0, '0, pred);
  endtask

  initial begin
    dir_row_t  dir_rows [24];
    out_item_t pred;
    int unsigned kind;
    dir_rows = '{
      '{'{OpMerge, 4'd0,  32'h0000_0000, 1'b0}, 1'b1, '{32'h0000_0000, 4'd0,  1'b0, 1'b0}},
      '{'{OpLoad,  4'd9,  32'h0000_007B, 1'b0}, 1'b0, '0},
      '{'{OpLoad,  4'd3,  32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd0,  32'h8000_0000, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd15, 32'h0000_0000, 1'b1}, 1'b0, '0},
      '{'{OpMerge, 4'd0,  32'hDEAD_BEEF, 1'b0}, 1'b1, '{32'h8000_0000, 4'd0,  1'b1, 1'b0}},
      '{'{OpMerge, 4'd0,  32'h7FFF_FFFF, 1'b1}, 1'b1, '{32'h0000_0000, 4'd15, 1'b1, 1'b0}},
      '{'{OpMerge, 4'd15, 32'h0000_0000, 1'b0}, 1'b1, '{32'h7FFF_FFFF, 4'd0,  1'b1, 1'b0}},
      '{'{OpMerge, 4'd0,  32'h0000_0000, 1'b0}, 1'b1, '{32'h7FFF_FFFF, 4'd3,  1'b1, 1'b1}},
      '{'{OpMerge, 4'd0,  32'hFFFF_FFFF, 1'b0}, 1'b1, '{32'h0000_0000, 4'd0,  1'b0, 1'b0}},
      '{'{OpLoad,  4'd5,  32'h0000_000A, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd5,  32'h0000_000A, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd4,  32'h0000_000A, 1'b1}, 1'b0, '0},
      '{'{OpMerge, 4'd4,  32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{OpMerge, 4'd5,  32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{OpMerge, 4'd5,  32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{OpMerge, 4'd5,  32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{OpMerge, 4'd7,  32'h0000_0005, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{OpLoad,  4'd0,  32'hFFFF_FFFF, 1'b1}, 1'b0, '0},
      '{'{OpMerge, 4'd0,  32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{OpMerge, 4'd15, 32'h0000_0000, 1'b0}, 1'b0, '0},
      '{'{OpMerge, 4'd10, 32'h5555_5555, 1'b1}, 1'b0, '0},
      '{'{OpMerge, 4'd6,  32'hAAAA_AAAA, 1'b0}, 1'b1, '{32'h0000_0000, 4'd0,  1'b0, 1'b0}}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[r])
      send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want, pred);
    drain_results();

    while (items_sent < ItemTarget) begin
      calm_phase = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) run_merge_set();
      else if (kind < 9) run_noise();
      else run_fill_burst();
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0 && pending_min.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // check each result transfer and draw the next receiver hold-off
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_min.size() == 0) begin
          if (err_count < ReportMax)
            $display("unexpected result: value %0d source %0d valid %0b last %0b",
                     out_data_o.min_value, out_data_o.min_source,
                     out_data_o.valid_res, out_data_o.last);
          err_count++;
        end else begin
          want = pending_min.pop_front();
          if (out_data_o !== want) begin
            if (err_count < ReportMax)
              $display("mismatch: expected value %0d source %0d valid %0b last %0b, got value %0d source %0d valid %0b last %0b",
                       want.min_value, want.min_source, want.valid_res, want.last,
                       out_data_o.min_value, out_data_o.min_source,
                       out_data_o.valid_res, out_data_o.last);
            err_count++;
          end
        end
        rx_hold = calm_phase ? 0 : $urandom_range(0, 8);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_stall_i <= (rx_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
